// ===== src/fdp_pkg.sv =====
// Shared types, constants and helpers of the framed dual duty command parser.
package fdp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 4;
  localparam int unsigned AddrW = 2;

  // Configuration register indexes
  localparam logic [AddrW-1:0] CfgStartCode  = 2'd0;
  localparam logic [AddrW-1:0] CfgEndCode    = 2'd1;
  localparam logic [AddrW-1:0] CfgSplitCode  = 2'd2;
  localparam logic [AddrW-1:0] CfgFrameLimit = 2'd3;

  // Register reset values
  localparam logic [ByteW-1:0] StartCodeRst  = 8'h5F;
  localparam logic [ByteW-1:0] EndCodeRst    = 8'h2F;
  localparam logic [ByteW-1:0] SplitCodeRst  = 8'h72;
  localparam logic [PosW-1:0]  FrameLimitRst = 4'd15;

  // ASCII digit range
  localparam logic [ByteW-1:0] DigitZero = 8'h30;
  localparam logic [ByteW-1:0] DigitNine = 8'h39;

  typedef struct packed {
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] end_code;
    logic [ByteW-1:0] split_code;
    logic [PosW-1:0]  frame_limit;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] left;
    logic             left_open;
    logic [ByteW-1:0] right;
    logic             right_open;
    logic             split_seen;
  } frame_state_t;

  typedef struct packed {
    logic [ByteW-1:0] left_duty;
    logic [ByteW-1:0] right_duty;
    logic             split_found;
  } result_t;

  // Decimal accumulate: acc * 10 + digit, saturated at 255
  function automatic logic [ByteW-1:0] add_digit(input logic [ByteW-1:0] acc,
                                                 input logic [3:0]       digit);
    logic [11:0] sum;
    sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, digit};
    return (sum > 12'd255) ? 8'hFF : sum[ByteW-1:0];
  endfunction

endpackage

// ===== src/fdp_cfg.sv =====
// Configuration register bank of the command parser.
module fdp_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [fdp_pkg::AddrW-1:0] cfg_addr_i,
  input  logic [fdp_pkg::ByteW-1:0] cfg_data_i,
  output fdp_pkg::cfg_t            cfg_o
);

  fdp_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Write the addressed register on each request
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        fdp_pkg::CfgStartCode:  cfg_d.start_code  = cfg_data_i;
        fdp_pkg::CfgEndCode:    cfg_d.end_code    = cfg_data_i;
        fdp_pkg::CfgSplitCode:  cfg_d.split_code  = cfg_data_i;
        fdp_pkg::CfgFrameLimit: cfg_d.frame_limit = cfg_data_i[fdp_pkg::PosW-1:0];
        default:                cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code  <= fdp_pkg::StartCodeRst;
      cfg_q.end_code    <= fdp_pkg::EndCodeRst;
      cfg_q.split_code  <= fdp_pkg::SplitCodeRst;
      cfg_q.frame_limit <= fdp_pkg::FrameLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/fdp_parse.sv =====
// Frame state update and result register of the command parser.
module fdp_parse (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fdp_pkg::cfg_t             cfg_i,
  input  logic [fdp_pkg::PosW-1:0]  limit_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [fdp_pkg::ByteW-1:0] in_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output fdp_pkg::result_t          out_o
);

  fdp_pkg::frame_state_t st_q, st_d, st_clr;
  fdp_pkg::result_t      res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  logic                  adv, fire;
  logic                  is_start, is_end, is_split, is_digit;
  logic [3:0]            digit;

  // Take a byte whenever the result register is free or being drained
  assign adv        = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && adv;
  assign in_ready_o = adv;

  assign is_start = (in_byte_i == cfg_i.start_code);
  assign is_end   = (in_byte_i == cfg_i.end_code);
  assign is_split = (in_byte_i == cfg_i.split_code);
  assign is_digit = (in_byte_i >= fdp_pkg::DigitZero) && (in_byte_i <= fdp_pkg::DigitNine);
  assign digit    = 4'(in_byte_i - fdp_pkg::DigitZero);

  always_comb begin
    st_clr            = '0;
    st_clr.left_open  = 1'b1;
  end

  // Advance the frame state for one byte
  always_comb begin
    st_d  = st_q;
    res_d = res_q;
    if (fire) begin
      priority if (is_start) begin
        st_d = st_q;
      end else if (is_end) begin
        res_d.left_duty   = st_q.split_seen ? st_q.left  : '0;
        res_d.right_duty  = st_q.split_seen ? st_q.right : st_q.left;
        res_d.split_found = st_q.split_seen;
        st_d              = st_clr;
      end else if (st_q.pos < limit_i) begin
        if (st_q.pos != '0) begin
          priority if (is_split) begin
            st_d.split_seen = 1'b1;
            st_d.left_open  = 1'b0;
            st_d.right      = '0;
            st_d.right_open = 1'b1;
          end else if (is_digit) begin
            if (st_q.left_open)  st_d.left  = fdp_pkg::add_digit(st_q.left, digit);
            if (st_q.right_open) st_d.right = fdp_pkg::add_digit(st_q.right, digit);
          end else begin
            st_d.left_open  = 1'b0;
            st_d.right_open = 1'b0;
          end
        end
        st_d.pos = st_q.pos + 1'b1;
      end
    end
  end

  // Hold the result until taken, load it on an end byte
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && !is_start && is_end) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= st_clr;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

  // Position stays within the full-width frame range of 15
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.pos <= 4'd15))
    else $error("frame position out of range");

  // Right field opens only after a split byte
  a_right_after_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.right_open |-> st_q.split_seen)
    else $error("right field open without split");

  // Frame is cleared after the end byte emits
  a_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !is_start && is_end) |=> (st_q.pos == '0 && !st_q.split_seen && out_valid_q))
    else $error("frame not cleared after end byte");

  // A result is never overwritten while waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !fire)
    else $error("byte taken while result stalled");

endmodule

// ===== src/framed_dual_duty_command_parser_core.sv =====
// Top level of the framed dual duty command parser: input register, parser, config.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata[7:0] rx_byte
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata[7:0] left_duty, [15:8] right_duty;
//                                                 tuser[0] split_found
//  cfg       in   cfg_valid_i/cfg_ready_o         cfg_addr_i index, cfg_data_i value
//
// One byte is accepted per cycle unless stalled; the frame state updates in a single pass.
// An end byte's result passes the input register, then the result register, before tvalid.
// A waiting result stalls the parser; an empty input register takes one byte, then tready drops.
// Reset clears the frame state and loads the default codes; config is always ready.
module framed_dual_duty_command_parser_core #(
  parameter int unsigned MAX_FRAME = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] left_duty, [15:8] right_duty
  output logic [0:0]  m_axis_tuser_o,   // [0] split_found
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i
);

  localparam logic [fdp_pkg::PosW-1:0] MaxFrameW = fdp_pkg::PosW'(MAX_FRAME);

  fdp_pkg::cfg_t             cfg;
  fdp_pkg::result_t          res;
  logic [fdp_pkg::PosW-1:0]  limit;
  logic                      in_valid_q, in_valid_d;
  logic [fdp_pkg::ByteW-1:0] in_byte_q, in_byte_d;
  logic                      stage_ready;
  logic                      s_fire;

  fdp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Clamp the frame limit to the built frame size
  assign limit = (cfg.frame_limit > MaxFrameW) ? MaxFrameW : cfg.frame_limit;

  // Input register: refill whenever it is empty or the held byte moves on
  assign s_axis_tready_o = !in_valid_q || stage_ready;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
    end
    if (s_fire) begin
      in_byte_d = s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
  end

  fdp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .limit_i     (limit),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (stage_ready),
    .in_byte_i   (in_byte_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {res.right_duty, res.left_duty};
  assign m_axis_tuser_o = res.split_found;

  // A request accepted into a full input register would be lost
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !stage_ready) |-> !s_axis_tready_o)
    else $error("input register overrun");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the framed dual duty command parser core.
module tb;

  localparam int unsigned MaxFrame    = 15;
  localparam int unsigned SettleCyc   = 6;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned ShownFails  = 10;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned RandomPhase = 5;

  typedef struct {
    logic [fdp_pkg::ByteW-1:0] ch;
    bit                        typed;
    fdp_pkg::result_t          want;
  } dir_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i      = '0;
  logic [7:0]  cfg_data_i      = '0;

  // Predictor state: register copy and command frame in progress
  fdp_pkg::cfg_t         codes;
  fdp_pkg::frame_state_t cmd_frame;
  fdp_pkg::result_t      duty_q[$];
  dir_row_t              dir_rows[$];

  int unsigned fail_cnt   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  int unsigned stall_pct  = 0;

  framed_dual_duty_command_parser_core dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_addr_i,
    .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= ShownFails) $display("%0d: %s", cycle_cnt, msg);
  endfunction

  function automatic void frame_clear();
    cmd_frame.pos        = '0;
    cmd_frame.left       = '0;
    cmd_frame.left_open  = 1'b1;
    cmd_frame.right      = '0;
    cmd_frame.right_open = 1'b0;
    cmd_frame.split_seen = 1'b0;
  endfunction

  // Shift in one decimal digit, pinning at 255
  function automatic logic [fdp_pkg::ByteW-1:0] dec_accumulate(
      input logic [fdp_pkg::ByteW-1:0] acc, input logic [fdp_pkg::ByteW-1:0] ch);
    int unsigned sum;
    sum = 10 * int'(acc) + int'(ch - fdp_pkg::DigitZero);
    return (sum > 255) ? 8'hFF : sum[7:0];
  endfunction

  // Advance the frame by one received byte; return 1 when a duty pair is due
  function automatic bit parse_byte(input logic [fdp_pkg::ByteW-1:0] b,
                                    output fdp_pkg::result_t duty);
    logic [fdp_pkg::PosW-1:0] lim;
    duty = '0;
    if (b == codes.start_code) return 1'b0;
    if (b == codes.end_code) begin
      duty.left_duty   = cmd_frame.split_seen ? cmd_frame.left : 8'd0;
      duty.right_duty  = cmd_frame.split_seen ? cmd_frame.right : cmd_frame.left;
      duty.split_found = cmd_frame.split_seen;
      frame_clear();
      return 1'b1;
    end
    lim = (codes.frame_limit > MaxFrame) ? fdp_pkg::PosW'(MaxFrame) : codes.frame_limit;
    if (cmd_frame.pos >= lim) return 1'b0;
    // The tag byte only moves the position on
    if (cmd_frame.pos != 0) begin
      if (b == codes.split_code) begin
        cmd_frame.split_seen = 1'b1;
        cmd_frame.left_open  = 1'b0;
        cmd_frame.right      = '0;
        cmd_frame.right_open = 1'b1;
      end else if (b >= fdp_pkg::DigitZero && b <= fdp_pkg::DigitNine) begin
        if (cmd_frame.left_open) cmd_frame.left = dec_accumulate(cmd_frame.left, b);
        if (cmd_frame.right_open) cmd_frame.right = dec_accumulate(cmd_frame.right, b);
      end else begin
        cmd_frame.left_open  = 1'b0;
        cmd_frame.right_open = 1'b0;
      end
    end
    cmd_frame.pos = cmd_frame.pos + 1'b1;
    return 1'b0;
  endfunction

  // Offer one request in bursts with random gaps; entered and left at a falling edge
  task automatic send_byte(input logic [fdp_pkg::ByteW-1:0] b, input bit typed = 1'b0,
                           input fdp_pkg::result_t want = '0);
    int unsigned      gap;
    fdp_pkg::result_t duty;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (parse_byte(b, duty)) duty_q.push_back(typed ? want : duty);
    items_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // Hold the input until every duty pair is out and the pipe has settled
  task automatic drain_duties();
    s_axis_tvalid_i = 1'b0;
    while (duty_q.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [fdp_pkg::AddrW-1:0] idx, input logic [7:0] val);
    cfg_valid_i = 1'b1;
    cfg_addr_i  = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fdp_pkg::CfgStartCode:  codes.start_code  = val;
      fdp_pkg::CfgEndCode:    codes.end_code    = val;
      fdp_pkg::CfgSplitCode:  codes.split_code  = val;
      fdp_pkg::CfgFrameLimit: codes.frame_limit = val[fdp_pkg::PosW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_codes(input logic [7:0] start_c, input logic [7:0] end_c,
                           input logic [7:0] split_c, input logic [3:0] limit);
    write_reg(fdp_pkg::CfgSplitCode, split_c);
    write_reg(fdp_pkg::CfgFrameLimit, {4'($urandom_range(0, 15)), limit});
    write_reg(fdp_pkg::CfgStartCode, start_c);
    write_reg(fdp_pkg::CfgEndCode, end_c);
  endtask

  // Mostly digits, now and then a start marker or a stray byte
  function automatic logic [fdp_pkg::ByteW-1:0] frame_char();
    int unsigned k;
    k = $urandom_range(0, 31);
    if (k == 0) return codes.start_code;
    if (k == 1) return 8'($urandom_range(0, 255));
    return fdp_pkg::DigitZero + 8'($urandom_range(0, 9));
  endfunction

  // One command frame in the current codes, or a short burst of noise
  task automatic send_frame();
    int unsigned n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'h61 + 8'($urandom_range(0, 25)));
    n = $urandom_range(0, 6);
    repeat (n) send_byte(frame_char());
    if ($urandom_range(0, 3) != 0) begin
      send_byte(codes.split_code);
      n = $urandom_range(0, 6);
      repeat (n) send_byte(frame_char());
      if ($urandom_range(0, 5) == 0) begin
        send_byte(codes.split_code);
        n = $urandom_range(0, 4);
        repeat (n) send_byte(frame_char());
      end
    end
    send_byte(codes.end_code);
  endtask

  task automatic add_row(input logic [7:0] ch, input bit typed = 1'b0,
                         input logic [7:0] l = 0, input logic [7:0] r = 0,
                         input logic s = 0);
    dir_row_t row;
    row.ch                 = ch;
    row.typed              = typed;
    row.want.left_duty     = l;
    row.want.right_duty    = r;
    row.want.split_found   = s;
    dir_rows.push_back(row);
  endtask

  // Receiver: random stalls whose density is redrawn among 0, 25 and 60 percent
  always @(negedge clk_i) begin
    if (cycle_cnt % 300 == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 60;
      endcase
    end
    if (stall_left != 0) begin
      m_axis_tready_i = 1'b0;
      stall_left--;
    end else begin
      m_axis_tready_i = 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 6);
    end
  end

  // Compare each delivered duty pair with the oldest one predicted
  always @(posedge clk_i) begin : duty_monitor
    fdp_pkg::result_t got;
    fdp_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.left_duty   = m_axis_tdata_o[7:0];
      got.right_duty  = m_axis_tdata_o[15:8];
      got.split_found = m_axis_tuser_o[0];
      if (duty_q.size() == 0) begin
        note_fail($sformatf("unexpected duty pair L=%0d R=%0d split=%0b",
                            got.left_duty, got.right_duty, got.split_found));
      end else begin
        want = duty_q.pop_front();
        if (got.left_duty !== want.left_duty || got.right_duty !== want.right_duty ||
            got.split_found !== want.split_found) begin
          note_fail($sformatf("duty mismatch: exp L=%0d R=%0d split=%0b, got L=%0d R=%0d split=%0b",
                              want.left_duty, want.right_duty, want.split_found,
                              got.left_duty, got.right_duty, got.split_found));
        end
      end
    end
  end

  // Stimulus
  initial begin
    static logic [7:0]  ph_start[NumPhases] =
        '{8'h5F, 8'h00, 8'hFF, 8'h2C, 8'h2F, 8'h00, 8'h35, 8'h5F};
    static logic [7:0]  ph_end[NumPhases]   =
        '{8'h2F, 8'hFF, 8'h00, 8'h41, 8'h2F, 8'h00, 8'h72, 8'h2F};
    static logic [7:0]  ph_split[NumPhases] =
        '{8'h72, 8'h30, 8'h39, 8'h41, 8'h72, 8'h00, 8'h72, 8'h72};
    static logic [3:0]  ph_limit[NumPhases] =
        '{4'd15, 4'd1, 4'd0, 4'd7, 4'd15, 4'd0, 4'd15, 4'd15};
    static int unsigned ph_items[NumPhases] = '{250, 200, 150, 200, 40, 250, 200, 260};
    bit                 paused;

    codes.start_code  = fdp_pkg::StartCodeRst;
    codes.end_code    = fdp_pkg::EndCodeRst;
    codes.split_code  = fdp_pkg::SplitCodeRst;
    codes.frame_limit = fdp_pkg::FrameLimitRst;
    frame_clear();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty frame
    add_row(8'h2F, 1, 0, 0, 0);
    // "l2_55r9/": start marker mid-frame, left exactly 255
    add_row(8'h6C); add_row(8'h32); add_row(8'h5F); add_row(8'h35);
    add_row(8'h35); add_row(8'h72); add_row(8'h39);
    add_row(8'h2F, 1, 255, 9, 1);
    // "x999/": no split, saturated value lands on the right
    add_row(8'h78); add_row(8'h39); add_row(8'h39); add_row(8'h39);
    add_row(8'h2F, 1, 0, 255, 0);
    // "rr1r7<nul>3/": split as tag byte, repeated split, zero byte closes the field
    add_row(8'h72); add_row(8'h72); add_row(8'h31); add_row(8'h72);
    add_row(8'h37); add_row(8'h00); add_row(8'h33); add_row(8'h2F);
    // All-ones tag byte
    add_row(8'hFF); add_row(8'h31); add_row(8'h2F);
    foreach (dir_rows[i]) send_byte(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);

    // Random frames under a run of register settings
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      if (ph != 0) begin
        drain_duties();
        if (ph == RandomPhase) begin
          set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
        end else begin
          set_codes(ph_start[ph], ph_end[ph], ph_split[ph], ph_limit[ph]);
        end
      end
      items_sent = 0;
      paused     = 1'b0;
      while (items_sent < ph_items[ph]) begin
        send_frame();
        if (!paused && items_sent >= ph_items[ph] / 2) begin
          drain_duties();
          paused = 1'b1;
        end
      end
    end

    drain_duties();
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
